// ----- rtl/core/xrfec_pkg.sv -----
// Shared types, codes and helper functions of the XOR row FEC encoder.
// Depends on nothing; every other file of the block but xrfec_ram imports it.
`default_nettype none

package xrfec_pkg;

   // Default sizes of the parity store and the length table.
   localparam int DEF_MAX_PACKET_BYTES  = 2048;
   localparam int DEF_MAX_GROUP_PACKETS = 16;

   // Fixed field widths of the two channels and the register port.
   localparam int REQ_TYPE_W = 2;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 12;
   localparam int SEQ_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int LEVEL_W    = 3;
   localparam int GSIZE_W    = 3;

   // Depth of the result queue and its pointer and fill widths.
   localparam int RSP_FIFO_DEPTH = 3;
   localparam int RSP_PTR_W      = 2;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_DATA  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TAKE  = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_FLUSH = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_GROUP_READY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT      = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TYPE = 1'd1;

   // One result transaction as held in the result queue.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0] resp_kind;
      logic [STATUS_W-1:0]   status;
      logic [BYTE_W-1:0]     read_byte;
      logic [LEN_W-1:0]      fec_size;
   } rsp_payload_type;

   // Packets per group for a protection level; zero means no protection.
   function automatic logic [GSIZE_W-1:0] group_size(input logic [LEVEL_W-1:0] level);
      logic [GSIZE_W-1:0] size;
      unique case (level)
         3'd1:    size = 3'd4;
         3'd2:    size = 3'd3;
         3'd3:    size = 3'd2;
         3'd4:    size = 3'd2;
         default: size = 3'd0;
      endcase
      return size;
   endfunction

   // Total FEC packet size: header, two bytes per packet, then the payload; zero for an empty group, capped at 4095.
   function automatic logic [LEN_W-1:0] fec_total(input logic [7:0] cnt,
                                                  input logic [LEN_W-1:0] longest);
      logic [LEN_W:0] total;
      total = 13'd8 + {4'b0, cnt, 1'b0} + {1'b0, longest};
      if (cnt == 8'd0) begin
         return '0;
      end
      return (total > 13'd4095) ? 12'hFFF : total[LEN_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/xrfec_channels.sv -----
// Handshake interfaces of the XOR row FEC encoder: request and result channels.
// Depends on xrfec_pkg for the field widths.
`default_nettype none

// Request channel: data bytes, FEC reads, take and flush.
interface xrfec_req_if import xrfec_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [BYTE_W-1:0]     data_byte;
   logic [LEN_W-1:0]      pkt_len;
   logic [SEQ_W-1:0]      seq;
   logic [LEN_W-1:0]      read_offset;

   modport source(output valid, req_type, data_byte, pkt_len, seq, read_offset,
                  input ready);
   modport sink(input valid, req_type, data_byte, pkt_len, seq, read_offset,
                output ready);
endinterface

// Result channel: one transaction per request.
interface xrfec_rsp_if import xrfec_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] resp_kind;
   logic [STATUS_W-1:0]   status;
   logic [BYTE_W-1:0]     read_byte;
   logic [LEN_W-1:0]      fec_size;

   modport source(output valid, resp_kind, status, read_byte, fec_size, input ready);
   modport sink(input valid, resp_kind, status, read_byte, fec_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/xrfec_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module xrfec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read; a read of the address being written returns old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/xrfec_rsp_fifo.sv -----
// Three-entry result queue that drives the result channel of the encoder.
// Depends on xrfec_pkg and the channel interfaces.
`default_nettype none

module xrfec_rsp_fifo import xrfec_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rsp_payload_type      push_data,
   output logic      [RSP_PTR_W-1:0] fill,
   xrfec_rsp_if.source               rsp_bus
);

   rsp_payload_type      q_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W-1:0] fill_ff, fill_in;
   logic                 pop;

   // Head entry goes straight to the channel.
   assign rsp_bus.valid     = (fill_ff != '0);
   assign rsp_bus.resp_kind = q_ff[rd_ptr_ff].resp_kind;
   assign rsp_bus.status    = q_ff[rd_ptr_ff].status;
   assign rsp_bus.read_byte = q_ff[rd_ptr_ff].read_byte;
   assign rsp_bus.fec_size  = q_ff[rd_ptr_ff].fec_size;
   assign fill              = fill_ff;
   assign pop               = rsp_bus.valid & rsp_bus.ready;

   // Pointer and fill bookkeeping; the writer never pushes into a full queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/xor_row_fec_encoder.sv -----
// Top level of the XOR row FEC encoder: request decode, group control, parity RMW.
// Depends on xrfec_pkg, the channel interfaces, xrfec_ram and xrfec_rsp_fifo.
`default_nettype none

// The encoder takes one request transaction per clock cycle and answers each
// with exactly one result transaction, in order, via the RAM stage and the
// result queue. Data bytes of accepted packets are XORed into a parity RAM
// that is read when the request is accepted and written back in the next
// cycle; a byte that follows at the same position is served from a bypass
// register, so full rate holds for any traffic. Reads of the FEC packet return
// one byte each: the header and the length table come from registers, the
// payload from the same RAM. The RAM needs no clearing after reset, since each
// group writes fresh positions before it ever XORs into them. A three-entry
// result queue lets the block keep accepting while results wait to be taken;
// requests stall when queue fill plus the RAM stage entry reaches its depth.
module xor_row_fec_encoder import xrfec_pkg::*; #(
   parameter int MAX_PACKET_BYTES  = DEF_MAX_PACKET_BYTES,
   parameter int MAX_GROUP_PACKETS = DEF_MAX_GROUP_PACKETS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   xrfec_req_if.sink                  req_bus,
   xrfec_rsp_if.source                rsp_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_PACKET_BYTES);
   localparam int CW = $clog2(MAX_GROUP_PACKETS + 1);
   localparam int TW = $clog2(MAX_GROUP_PACKETS);

   // Work carried from acceptance into the RAM stage.
   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [STATUS_W-1:0]   status;
      logic [LEN_W-1:0]      size;
      logic [BYTE_W-1:0]     rd_byte;
      logic                  use_ram;
      logic                  wr_en;
      logic                  xor_en;
      logic [AW-1:0]         addr;
      logic [BYTE_W-1:0]     data;
   } stage_type;

   // Group control state.
   logic [CW-1:0]         count_ff, count_in;
   logic [7:0]            group_ff, group_in;
   logic [15:0]           base_ff, base_in;
   logic [LEN_W-1:0]      longest_ff, longest_in;
   logic [LEN_W-1:0]      pos_ff, pos_in;
   logic                  dropping_ff, dropping_in;
   logic                  reject_ff, reject_in;
   logic [LEN_W-1:0]      held_len_ff, held_len_in;
   logic [LEVEL_W-1:0]    level_ff;
   logic [BYTE_W-1:0]     row_type_ff;
   logic [LEN_W-1:0]      len_table_ff [MAX_GROUP_PACKETS];

   // RAM stage and write-back bypass.
   stage_type             s1_ff, s1_in;
   logic                  s1_valid_ff;
   logic                  wb_valid_ff;
   logic [AW-1:0]         wb_addr_ff;
   logic [BYTE_W-1:0]     wb_data_ff;

   // Decode helpers.
   logic                  accept;
   logic                  table_we;
   logic                  do_close;
   logic                  first_byte;
   logic                  drop_eff;
   logic                  reject_eff;
   logic [LEN_W-1:0]      len_eff;
   logic [CW-1:0]         count_eff;
   logic [LEN_W-1:0]      longest_eff;
   logic [LEN_W:0]        pos_inc;
   logic [GSIZE_W-1:0]    gsize;
   logic [LEN_W-1:0]      total_now;
   logic [LEN_W-1:0]      tab_end;
   logic [LEN_W-1:0]      tbl_off;
   logic [LEN_W-2:0]      tbl_idx;
   logic [LEN_W-1:0]      tbl_entry;
   logic [LEN_W-1:0]      pay_off;

   // RAM stage signals.
   logic [BYTE_W-1:0]     ram_rd_data;
   logic [BYTE_W-1:0]     ram_q;
   logic [BYTE_W-1:0]     ram_wr_data;
   logic                  ram_wr_en;
   rsp_payload_type       rsp_data;
   logic [RSP_PTR_W-1:0]  rsp_fill;

   // Take a request while the queue has room for everything in flight.
   assign req_bus.ready = ({1'b0, rsp_fill} + {2'b0, s1_valid_ff})
                          < (RSP_PTR_W + 1)'(RSP_FIFO_DEPTH);
   assign accept        = req_bus.valid & req_bus.ready;

   // Request decode and next group state.
   always_comb begin
      count_in    = count_ff;
      group_in    = group_ff;
      base_in     = base_ff;
      longest_in  = longest_ff;
      pos_in      = pos_ff;
      dropping_in = dropping_ff;
      reject_in   = reject_ff;
      held_len_in = held_len_ff;
      table_we    = 1'b0;
      do_close    = 1'b0;

      gsize       = group_size(level_ff);
      total_now   = fec_total(8'(count_ff), longest_ff);
      tab_end     = 12'd8 + LEN_W'({count_ff, 1'b0});
      first_byte  = (pos_ff == '0);
      drop_eff    = dropping_ff;
      reject_eff  = reject_ff;
      len_eff     = held_len_ff;
      count_eff   = count_ff;
      longest_eff = longest_ff;
      pos_inc     = {1'b0, pos_ff} + 13'd1;

      tbl_off     = req_bus.read_offset - 12'd8;
      tbl_idx     = tbl_off[LEN_W-1:1];
      tbl_entry   = '0;
      if (tbl_idx < (LEN_W - 1)'(MAX_GROUP_PACKETS)) begin
         tbl_entry = len_table_ff[tbl_idx[TW-1:0]];
      end
      pay_off     = req_bus.read_offset - tab_end;

      s1_in.kind    = req_bus.req_type;
      s1_in.status  = ST_DONE;
      s1_in.size    = total_now;
      s1_in.rd_byte = '0;
      s1_in.use_ram = 1'b0;
      s1_in.wr_en   = 1'b0;
      s1_in.xor_en  = 1'b0;
      s1_in.addr    = '0;
      s1_in.data    = req_bus.data_byte;

      unique case (req_bus.req_type)
         REQ_DATA: begin
            // The first byte of a packet decides whether the packet joins the group.
            if (first_byte) begin
               len_eff     = req_bus.pkt_len;
               held_len_in = req_bus.pkt_len;
               priority if (req_bus.pkt_len == '0 ||
                            req_bus.pkt_len > LEN_W'(MAX_PACKET_BYTES)) begin
                  drop_eff   = 1'b1;
                  reject_eff = 1'b1;
               end else if (gsize == '0) begin
                  drop_eff   = 1'b1;
                  reject_eff = 1'b0;
               end else if (count_ff >= CW'(MAX_GROUP_PACKETS)) begin
                  drop_eff   = 1'b1;
                  reject_eff = 1'b1;
               end else begin
                  if (count_ff == '0) begin
                     base_in = req_bus.seq[15:0];
                  end
                  table_we  = 1'b1;
                  count_eff = count_ff + 1'b1;
                  drop_eff  = 1'b0;
               end
            end
            dropping_in = drop_eff;
            reject_in   = reject_eff;
            count_in    = count_eff;

            // Accepted bytes XOR into known positions and extend the payload otherwise.
            if (!drop_eff) begin
               if (pos_ff < LEN_W'(MAX_PACKET_BYTES)) begin
                  s1_in.wr_en = 1'b1;
                  s1_in.addr  = pos_ff[AW-1:0];
                  if (pos_ff < longest_ff) begin
                     s1_in.xor_en = 1'b1;
                  end else begin
                     longest_eff = pos_inc[LEN_W-1:0];
                  end
               end
               if (pos_inc >= {1'b0, len_eff} && gsize != '0 &&
                   8'(count_eff) >= 8'(gsize)) begin
                  s1_in.status = ST_GROUP_READY;
               end
            end else begin
               s1_in.status = reject_eff ? ST_REJECT : ST_DONE;
            end

            pos_in      = (pos_inc >= {1'b0, len_eff}) ? '0 : pos_inc[LEN_W-1:0];
            longest_in  = longest_eff;
            s1_in.size  = fec_total(8'(count_eff), longest_eff);
         end
         REQ_READ: begin
            // Header and length table from registers, payload from the RAM.
            if (req_bus.read_offset < total_now) begin
               priority if (req_bus.read_offset < 12'd8) begin
                  unique case (req_bus.read_offset[2:0])
                     3'd0: s1_in.rd_byte = row_type_ff;
                     3'd1: s1_in.rd_byte = group_ff;
                     3'd2: s1_in.rd_byte = 8'(count_ff);
                     3'd3: s1_in.rd_byte = 8'd0;
                     3'd4: s1_in.rd_byte = {4'b0, longest_ff[11:8]};
                     3'd5: s1_in.rd_byte = longest_ff[7:0];
                     3'd6: s1_in.rd_byte = base_ff[15:8];
                     3'd7: s1_in.rd_byte = base_ff[7:0];
                     default: s1_in.rd_byte = 8'd0;
                  endcase
               end else if (req_bus.read_offset < tab_end) begin
                  s1_in.rd_byte = tbl_off[0] ? tbl_entry[7:0] : {4'b0, tbl_entry[11:8]};
               end else if (pay_off < LEN_W'(MAX_PACKET_BYTES)) begin
                  s1_in.use_ram = 1'b1;
                  s1_in.addr    = pay_off[AW-1:0];
               end
            end else begin
               s1_in.status = ST_REJECT;
            end
         end
         REQ_TAKE: begin
            do_close = 1'b1;
         end
         REQ_FLUSH: begin
            do_close = (count_ff != '0);
         end
         default: begin
            do_close = 1'b0;
         end
      endcase

      // Closing a group; a packet cut short loses its remaining bytes.
      if (do_close) begin
         count_in   = '0;
         longest_in = '0;
         group_in   = group_ff + 8'd1;
         if (pos_ff != '0 && !dropping_ff) begin
            dropping_in = 1'b1;
            reject_in   = 1'b1;
         end
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         group_ff    <= '0;
         base_ff     <= '0;
         longest_ff  <= '0;
         pos_ff      <= '0;
         dropping_ff <= 1'b0;
         reject_ff   <= 1'b0;
         held_len_ff <= '0;
         s1_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff    <= count_in;
            group_ff    <= group_in;
            base_ff     <= base_in;
            longest_ff  <= longest_in;
            pos_ff      <= pos_in;
            dropping_ff <= dropping_in;
            reject_ff   <= reject_in;
            held_len_ff <= held_len_in;
         end
         s1_valid_ff <= accept;
         wb_valid_ff <= ram_wr_en;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         row_type_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEVEL:    level_ff    <= csr_wr_data[LEVEL_W-1:0];
            CSR_ROW_TYPE: row_type_ff <= csr_wr_data;
            default:      level_ff    <= level_ff;
         endcase
      end
   end

   // Length table and stage payload.
   always_ff @(posedge clock) begin
      if (accept && table_we) begin
         len_table_ff[count_ff[TW-1:0]] <= req_bus.pkt_len;
      end
      if (accept) begin
         s1_ff <= s1_in;
      end
      wb_addr_ff <= s1_ff.addr;
      wb_data_ff <= ram_wr_data;
   end

   // RAM stage: bypass the write of the previous cycle, then modify and write back.
   assign ram_q       = (wb_valid_ff && wb_addr_ff == s1_ff.addr) ? wb_data_ff : ram_rd_data;
   assign ram_wr_data = s1_ff.xor_en ? (ram_q ^ s1_ff.data) : s1_ff.data;
   assign ram_wr_en   = s1_valid_ff & s1_ff.wr_en;

   xrfec_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(MAX_PACKET_BYTES)
   ) u_parity_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(s1_ff.addr),
      .wr_data(ram_wr_data),
      .rd_addr(s1_in.addr),
      .rd_data(ram_rd_data)
   );

   // Result assembly into the queue.
   always_comb begin
      rsp_data.resp_kind = s1_ff.kind;
      rsp_data.status    = s1_ff.status;
      rsp_data.read_byte = s1_ff.use_ram ? ram_q : s1_ff.rd_byte;
      rsp_data.fec_size  = s1_ff.size;
   end

   xrfec_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_valid_ff),
      .push_data(rsp_data),
      .fill     (rsp_fill),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench of the XOR row FEC encoder: a directed plan, then random traffic.
// Depends on xrfec_pkg, the channel interfaces and the xor_row_fec_encoder RTL.
// Results are checked against a behavioral parity and header predictor kept in this module.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import xrfec_pkg::*;

   localparam int RANDOM_ITEMS = 1700;

   // Clock, reset and the register port.
   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   xrfec_req_if req_bus();
   xrfec_rsp_if rsp_bus();

   xor_row_fec_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Encoder state as the predictor sees it.
   logic [BYTE_W-1:0]  parity_mem [0:DEF_MAX_PACKET_BYTES-1];
   logic [LEN_W-1:0]   len_table [0:DEF_MAX_GROUP_PACKETS-1];
   logic [4:0]         pkt_count;
   logic [7:0]         grp_id;
   logic [15:0]        base_seq;
   logic [LEN_W-1:0]   longest;
   logic [LEN_W-1:0]   byte_pos;
   logic [LEN_W-1:0]   held_len;
   bit                 dropping;
   bit                 drop_rejects;
   logic [LEVEL_W-1:0] cfg_level;
   logic [7:0]         cfg_row_type;

   // Results still owed by the encoder, oldest first.
   rsp_payload_type pending_fec_rsp[$];
   rsp_payload_type want_rsp;
   rsp_payload_type seen_rsp;
   int              mismatch_count;

   // Typed expectation that travels with the request being driven.
   bit              use_typed;
   rsp_payload_type typed_expect;

   // Sender and receiver pacing.
   int burst_left;
   int stall_mode;
   int stall_tick;
   int random_items;
   int phase_level;

   // One directed plan row: a run of requests or a register write.
   typedef enum bit {ROW_REQ, ROW_CSR} row_kind_e;
   typedef struct {
      row_kind_e             what;
      logic [REQ_TYPE_W-1:0] kind;
      logic [BYTE_W-1:0]     data;
      logic [LEN_W-1:0]      len;
      logic [SEQ_W-1:0]      sq;
      logic [LEN_W-1:0]      off;
      int                    count;
      bit                    typed;
      logic [STATUS_W-1:0]   st;
      logic [BYTE_W-1:0]     rb;
      logic [LEN_W-1:0]      sz;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
   } plan_row_t;

   plan_row_t plan[$];

   // Packets per group for a level; zero means the level protects nothing.
   function automatic int protect_group(logic [LEVEL_W-1:0] lv);
      case (lv)
         3'd1:    return 4;
         3'd2:    return 3;
         3'd3:    return 2;
         3'd4:    return 2;
         default: return 0;
      endcase
   endfunction

   // Size of the FEC packet of the open group.
   function automatic int fec_length();
      int total;
      if (pkt_count == 0) begin
         return 0;
      end
      total = 8 + 2 * int'(pkt_count) + int'(longest);
      return (total > 4095) ? 4095 : total;
   endfunction

   // One byte of the FEC packet: header, length table, then parity payload.
   function automatic logic [7:0] fec_byte_at(int off);
      int tab_end;
      int k;
      tab_end = 8 + 2 * int'(pkt_count);
      case (off)
         0: return cfg_row_type;
         1: return grp_id;
         2: return {3'b0, pkt_count};
         3: return 8'h00;
         4: return {4'h0, longest[11:8]};
         5: return longest[7:0];
         6: return base_seq[15:8];
         7: return base_seq[7:0];
         default: ;
      endcase
      if (off < tab_end) begin
         k = (off - 8) / 2;
         if (k >= DEF_MAX_GROUP_PACKETS) begin
            return 8'h00;
         end
         return ((off - 8) % 2 == 0) ? {4'h0, len_table[k][11:8]} : len_table[k][7:0];
      end
      k = off - tab_end;
      if (k >= DEF_MAX_PACKET_BYTES) begin
         return 8'h00;
      end
      return parity_mem[k];
   endfunction

   // Closing a group empties it; a packet that is half in goes on being dropped.
   function automatic void close_group();
      pkt_count = '0;
      longest   = '0;
      grp_id    = grp_id + 8'd1;
      if (byte_pos != 0 && !dropping) begin
         dropping     = 1'b1;
         drop_rejects = 1'b1;
      end
   endfunction

   function automatic void reset_model();
      pkt_count    = '0;
      grp_id       = '0;
      base_seq     = '0;
      longest      = '0;
      byte_pos     = '0;
      held_len     = '0;
      dropping     = 1'b0;
      drop_rejects = 1'b0;
      cfg_level    = '0;
      cfg_row_type = '0;
   endfunction

   // Advance the encoder state by one request and return its result.
   function automatic rsp_payload_type encode_step(logic [REQ_TYPE_W-1:0] kind,
                                                   logic [BYTE_W-1:0] data,
                                                   logic [LEN_W-1:0] len,
                                                   logic [SEQ_W-1:0] sq,
                                                   logic [LEN_W-1:0] off);
      rsp_payload_type r;
      int p;
      int g;
      int size;
      r.resp_kind = kind;
      r.status    = ST_DONE;
      r.read_byte = '0;
      r.fec_size  = '0;
      case (kind)
         REQ_DATA: begin
            // The first byte of a packet decides whether it joins the group.
            if (byte_pos == 0) begin
               held_len = len;
               if (len == 0 || int'(len) > DEF_MAX_PACKET_BYTES) begin
                  dropping     = 1'b1;
                  drop_rejects = 1'b1;
               end else if (protect_group(cfg_level) == 0) begin
                  dropping     = 1'b1;
                  drop_rejects = 1'b0;
               end else if (int'(pkt_count) >= DEF_MAX_GROUP_PACKETS) begin
                  dropping     = 1'b1;
                  drop_rejects = 1'b1;
               end else begin
                  if (pkt_count == 0) begin
                     base_seq = sq[15:0];
                  end
                  len_table[pkt_count] = len;
                  pkt_count            = pkt_count + 5'd1;
                  dropping             = 1'b0;
               end
            end
            if (!dropping) begin
               // Fresh positions are written, known ones are XORed.
               p = int'(byte_pos);
               if (p < DEF_MAX_PACKET_BYTES) begin
                  if (p < int'(longest)) begin
                     parity_mem[p] = parity_mem[p] ^ data;
                  end else begin
                     parity_mem[p] = data;
                     longest       = LEN_W'(p + 1);
                  end
               end
               if (p + 1 >= int'(held_len)) begin
                  g = protect_group(cfg_level);
                  if (g != 0 && int'(pkt_count) >= g) begin
                     r.status = ST_GROUP_READY;
                  end
               end
            end else begin
               r.status = drop_rejects ? ST_REJECT : ST_DONE;
            end
            if (int'(byte_pos) + 1 >= int'(held_len)) begin
               byte_pos = '0;
            end else begin
               byte_pos = byte_pos + 12'd1;
            end
            r.fec_size = LEN_W'(fec_length());
         end
         REQ_READ: begin
            size       = fec_length();
            r.fec_size = LEN_W'(size);
            if (int'(off) < size) begin
               r.read_byte = fec_byte_at(int'(off));
            end else begin
               r.status = ST_REJECT;
            end
         end
         REQ_TAKE: begin
            r.fec_size = LEN_W'(fec_length());
            close_group();
         end
         default: begin
            r.fec_size = LEN_W'(fec_length());
            if (pkt_count != 0) begin
               close_group();
            end
         end
      endcase
      return r;
   endfunction

   // Print one line per mismatch, up to a cap, and count all of them.
   task automatic report(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      end
   endtask

   // Watch the register port and both channels at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LEVEL:    cfg_level    = csr_wr_data[LEVEL_W-1:0];
               CSR_ROW_TYPE: cfg_row_type = csr_wr_data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            want_rsp = encode_step(req_bus.req_type, req_bus.data_byte, req_bus.pkt_len,
                                   req_bus.seq, req_bus.read_offset);
            pending_fec_rsp.push_back(use_typed ? typed_expect : want_rsp);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.resp_kind = rsp_bus.resp_kind;
            seen_rsp.status    = rsp_bus.status;
            seen_rsp.read_byte = rsp_bus.read_byte;
            seen_rsp.fec_size  = rsp_bus.fec_size;
            if (pending_fec_rsp.size() == 0) begin
               report("transaction with nothing pending, resp_kind", seen_rsp.resp_kind, -1);
            end else begin
               want_rsp = pending_fec_rsp.pop_front();
               if (seen_rsp.resp_kind !== want_rsp.resp_kind)
                  report("resp_kind", seen_rsp.resp_kind, want_rsp.resp_kind);
               if (seen_rsp.status !== want_rsp.status)
                  report("status", seen_rsp.status, want_rsp.status);
               if (seen_rsp.read_byte !== want_rsp.read_byte)
                  report("read_byte", seen_rsp.read_byte, want_rsp.read_byte);
               if (seen_rsp.fec_size !== want_rsp.fec_size)
                  report("fec_size", seen_rsp.fec_size, want_rsp.fec_size);
            end
         end
      end
   end

   // Receiver stalls follow a pattern that changes every so often.
   always @(posedge clock) begin
      stall_tick++;
      if (stall_tick % 160 == 0) begin
         stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= (stall_tick % 4) != 0;
         2:       rsp_bus.ready <= 1'($urandom_range(0, 1));
         default: rsp_bus.ready <= (stall_tick % 19) >= 7;
      endcase
   end

   // Drive one request transaction and wait until it is taken.
   task automatic send_req(input logic [REQ_TYPE_W-1:0] kind, input logic [BYTE_W-1:0] data,
                           input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] sq,
                           input logic [LEN_W-1:0] off, input bit typed,
                           input rsp_payload_type typed_rsp);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= kind;
      req_bus.data_byte   <= data;
      req_bus.pkt_len     <= len;
      req_bus.seq         <= sq;
      req_bus.read_offset <= off;
      use_typed           <= typed;
      typed_expect        <= typed_rsp;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Random-traffic request, counted unless the encoder merely ignores it.
   task automatic send_random(input logic [REQ_TYPE_W-1:0] kind, input logic [BYTE_W-1:0] data,
                              input logic [LEN_W-1:0] len, input logic [SEQ_W-1:0] sq,
                              input logic [LEN_W-1:0] off);
      send_req(kind, data, len, sq, off, 1'b0, '0);
      if (kind != REQ_DATA || protect_group(LEVEL_W'(phase_level)) != 0) begin
         random_items++;
      end
   endtask

   // Stop sending and wait until every owed result has come back.
   task automatic quiesce();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_fec_rsp.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic plan_row_t req_row(logic [REQ_TYPE_W-1:0] kind, logic [BYTE_W-1:0] data,
                                         logic [LEN_W-1:0] len, logic [SEQ_W-1:0] sq,
                                         logic [LEN_W-1:0] off, int count, bit typed,
                                         logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] rb,
                                         logic [LEN_W-1:0] sz);
      plan_row_t r;
      r.what  = ROW_REQ;
      r.kind  = kind;
      r.data  = data;
      r.len   = len;
      r.sq    = sq;
      r.off   = off;
      r.count = count;
      r.typed = typed;
      r.st    = st;
      r.rb    = rb;
      r.sz    = sz;
      r.idx   = '0;
      r.val   = '0;
      return r;
   endfunction

   function automatic plan_row_t csr_row(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      plan_row_t r;
      r       = req_row(REQ_DATA, '0, '0, '0, '0, 0, 1'b0, ST_DONE, '0, '0);
      r.what  = ROW_CSR;
      r.idx   = idx;
      r.val   = val;
      return r;
   endfunction

   // One well-formed packet, now and then cut into by a read, take or flush.
   task automatic random_packet(input int close_pct);
      int len;
      int cut;
      int i;
      logic [SEQ_W-1:0] sq;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 80) : $urandom_range(1, 20);
      cut = ($urandom_range(0, 99) < 8 && len > 1) ? $urandom_range(1, len - 1) : -1;
      sq  = $urandom;
      for (i = 0; i < len; i++) begin
         if (i == cut) begin
            case ($urandom_range(0, 2))
               0:       send_random(REQ_READ, '0, '0, '0, LEN_W'($urandom_range(0, 120)));
               1:       send_random(REQ_TAKE, '0, '0, '0, '0);
               default: send_random(REQ_FLUSH, '0, '0, '0, '0);
            endcase
         end
         send_random(REQ_DATA, BYTE_W'($urandom), LEN_W'(len), sq, '0);
      end
   endtask

   // One random phase: a fresh setting, then mixed traffic until idle.
   task automatic random_phase();
      int pick;
      int start;
      int n_items;
      int close_pct;
      int n;
      logic [7:0] row_type;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         phase_level = 0;
      else if (pick == 1)
         phase_level = $urandom_range(5, 7);
      else
         phase_level = $urandom_range(1, 4);
      pick = $urandom_range(0, 9);
      row_type = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      // Upper data bits of the level write are don't-care and get random values.
      write_csr(CSR_LEVEL, {5'($urandom), 3'(phase_level)});
      write_csr(CSR_ROW_TYPE, row_type);
      close_pct = $urandom_range(1, 12);
      start     = random_items;
      n_items   = $urandom_range(60, 220);
      while (random_items - start < n_items && random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            random_packet(close_pct);
         end else if (pick < 68 + close_pct) begin
            send_random(($urandom_range(0, 1) == 0) ? REQ_TAKE : REQ_FLUSH, '0, '0, '0, '0);
         end else if (pick < 92) begin
            n = $urandom_range(1, 6);
            repeat (n) send_random(REQ_READ, '0, '0, '0, LEN_W'($urandom_range(0, 120)));
         end else begin
            // Noise: empty-length packets, reads anywhere in the offset range and flushes.
            case ($urandom_range(0, 2))
               0:       send_random(REQ_DATA, BYTE_W'($urandom), '0, $urandom, '0);
               1:       send_random(REQ_READ, '0, '0, '0, LEN_W'($urandom));
               default: send_random(REQ_FLUSH, '0, '0, '0, '0);
            endcase
         end
      end
      quiesce();
   endtask

   // Main sequence: reset, directed plan, random phases, then the verdict.
   initial begin
      plan_row_t row;
      rsp_payload_type typed_rsp;
      int i;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.req_type    = REQ_DATA;
      req_bus.data_byte   = '0;
      req_bus.pkt_len     = '0;
      req_bus.seq         = '0;
      req_bus.read_offset = '0;
      rsp_bus.ready       = 1'b0;
      use_typed           = 1'b0;
      typed_expect        = '0;
      burst_left          = 0;
      stall_mode          = 0;
      stall_tick          = 0;
      random_items        = 0;
      phase_level         = 0;
      mismatch_count      = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed plan. Level none after reset: data is ignored, the group stays empty.
      plan.push_back(req_row(REQ_DATA, 8'h5A, 12'd5, 32'h0, '0, 5, 1, ST_DONE, 8'h00, 12'd0));
      plan.push_back(req_row(REQ_READ, 8'h00, 12'd0, 32'h0, '0, 1, 1, ST_REJECT, 8'h00, 12'd0));
      plan.push_back(req_row(REQ_FLUSH, 8'h00, 12'd0, 32'h0, '0, 1, 1, ST_DONE, 8'h00, 12'd0));
      plan.push_back(req_row(REQ_TAKE, 8'h00, 12'd0, 32'h0, '0, 1, 1, ST_DONE, 8'h00, 12'd0));
      plan.push_back(csr_row(CSR_LEVEL, 8'd1));
      plan.push_back(csr_row(CSR_ROW_TYPE, 8'hFF));
      // Bad lengths are rejected on every byte: zero, the widest, and one past the maximum.
      plan.push_back(req_row(REQ_DATA, 8'h11, 12'd0, 32'h0, '0, 1, 1, ST_REJECT, 8'h00, 12'd0));
      plan.push_back(req_row(REQ_DATA, 8'hFF, 12'd4095, 32'hFFFF_FFFF, '0, 4095, 1,
                             ST_REJECT, 8'h00, 12'd0));
      plan.push_back(req_row(REQ_DATA, 8'h00, 12'd2049, 32'h0, '0, 2049, 1,
                             ST_REJECT, 8'h00, 12'd0));
      // A packet of the largest length, then one-byte packets until the group is full.
      plan.push_back(req_row(REQ_DATA, 8'hFF, 12'd2048, 32'hFFFF_FFFF, '0, 2048, 0,
                             ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_DATA, 8'hC3, 12'd1, 32'h0000_8001, '0, 15, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_DATA, 8'h77, 12'd1, 32'h0, '0, 1, 0, ST_DONE, '0, '0));
      // Read the whole FEC packet and two bytes past its end, then the last offset.
      plan.push_back(req_row(REQ_READ, 8'h00, 12'd0, 32'h0, 12'd0, 2090, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_READ, 8'h00, 12'd0, 32'h0, 12'd4095, 1, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_TAKE, 8'h00, 12'd0, 32'h0, '0, 1, 0, ST_DONE, '0, '0));
      // A level change in mid-packet leaves the first-byte decision in force.
      plan.push_back(req_row(REQ_DATA, 8'h21, 12'd3, 32'h0000_0000, '0, 2, 0, ST_DONE, '0, '0));
      plan.push_back(csr_row(CSR_LEVEL, 8'd5));
      plan.push_back(req_row(REQ_DATA, 8'h40, 12'd3, 32'h0, '0, 1, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_DATA, 8'h90, 12'd2, 32'h0, '0, 2, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_READ, 8'h00, 12'd0, 32'h0, 12'd0, 16, 0, ST_DONE, '0, '0));
      // A flush in mid-packet closes the group; the rest of that packet is rejected.
      plan.push_back(csr_row(CSR_LEVEL, 8'd4));
      plan.push_back(req_row(REQ_DATA, 8'hA0, 12'd4, 32'h1234_5678, '0, 2, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_FLUSH, 8'h00, 12'd0, 32'h0, '0, 1, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_DATA, 8'hB0, 12'd4, 32'h0, '0, 2, 0, ST_DONE, '0, '0));
      plan.push_back(req_row(REQ_FLUSH, 8'h00, 12'd0, 32'h0, '0, 1, 1, ST_DONE, 8'h00, 12'd0));
      plan.push_back(csr_row(CSR_ROW_TYPE, 8'h00));
      plan.push_back(csr_row(CSR_LEVEL, 8'hF8));

      foreach (plan[r]) begin
         row = plan[r];
         if (row.what == ROW_CSR) begin
            quiesce();
            write_csr(row.idx, row.val);
         end else begin
            typed_rsp.resp_kind = row.kind;
            typed_rsp.status    = row.st;
            typed_rsp.read_byte = row.rb;
            typed_rsp.fec_size  = row.sz;
            for (i = 0; i < row.count; i++) begin
               send_req(row.kind, row.data + BYTE_W'(i), row.len, row.sq,
                        row.off + LEN_W'(i), row.typed, typed_rsp);
            end
         end
      end
      quiesce();

      // Random phases until enough traffic has gone through.
      while (random_items < RANDOM_ITEMS) begin
         random_phase();
      end
      quiesce();
      repeat (20) @(posedge clock);

      if (pending_fec_rsp.size() != 0) begin
         report("results never returned", pending_fec_rsp.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
